/* rtl/lobm_pkg.sv */
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the order book matcher
// Widths, command and status codes, and the slot record.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam int BOOK_DEPTH = 64;
	localparam int PRICE_BITS = 16;
	localparam int QTY_BITS   = 24;
	localparam int ID_BITS    = 32;
	localparam int SLOT_BITS  = $clog2(BOOK_DEPTH);
	localparam int CNT_BITS   = $clog2(BOOK_DEPTH + 1);
	localparam int MAX_FILLS  = BOOK_DEPTH - 1;

	localparam logic [1:0] CMD_PLACE  = 2'd0;
	localparam logic [1:0] CMD_CANCEL = 2'd1;
	localparam logic [1:0] CMD_REDUCE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_ZERO    = 2'd3;

	localparam logic KIND_FILL    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [QTY_BITS-1:0]   qty;
		logic [ID_BITS-1:0]    ident;
	} slot_t;

endpackage

/* rtl/lobm_slot_ram.sv */
// ----------------------------------------------------------------------------
// lobm_slot_ram: order slot store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module lobm_slot_ram (
	input  logic                           clk,
	input  logic                           we,
	input  logic [lobm_pkg::SLOT_BITS-1:0] waddr,
	input  lobm_pkg::slot_t                wdata,
	input  logic [lobm_pkg::SLOT_BITS-1:0] raddr,
	output lobm_pkg::slot_t                rdata
);
	lobm_pkg::slot_t mem_q [lobm_pkg::BOOK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/limit_order_book_matcher.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority order book
// Place, cancel and reduce commands against a 64-slot book.
// ----------------------------------------------------------------------------
// Usage:
// One command item enters on the input valid/ready channel; ready is low
// while a command is processed. Results leave on the output channel: one
// fill item per matched resting order, then a summary item with last high.
// Every search sweeps the slot store through its single read port, one slot
// a cycle. Cancel and reduce take one sweep; a place sweeps once per fill,
// once more for a search that finds no match, and once for a free slot if
// quantity remains. Each result is held in an output register; the sequencer
// waits while the receiver stalls and nothing is lost. Reset empties the book
// (valid bits cleared at once) and zeroes the id counter; slot contents are
// not cleared.
// ----------------------------------------------------------------------------
module limit_order_book_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [31:0] target_id,
	input  logic [15:0] limit_price,
	input  logic [23:0] amount,
	input  logic        buy_sell,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [31:0] own_id,
	output logic [31:0] resting_id,
	output logic [23:0] fill_amount,
	output logic [23:0] remaining,
	output logic [1:0]  status,
	output logic [6:0]  resting_count,
	output logic        last
);
	localparam int SB = lobm_pkg::SLOT_BITS;
	localparam int QB = lobm_pkg::QTY_BITS;
	localparam int PB = lobm_pkg::PRICE_BITS;
	localparam int IB = lobm_pkg::ID_BITS;
	localparam int CB = lobm_pkg::CNT_BITS;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_DEC   = 3'd2;
	localparam logic [2:0] S_RDBST = 3'd3;
	localparam logic [2:0] S_FILL  = 3'd4;
	localparam logic [2:0] S_WAIT  = 3'd5;
	localparam logic [2:0] S_FREE  = 3'd6;

	logic [2:0]    state_q;
	logic [1:0]    cmd_q;
	logic [IB-1:0] tid_q;
	logic [PB-1:0] price_q;
	logic [QB-1:0] amt_q;
	logic          side_q;
	logic [IB-1:0] id_q;
	logic [IB-1:0] idc_q;
	logic [QB-1:0] rem_q;
	logic [CB-1:0] book_q;
	logic [CB-1:0] nfill_q;
	logic [lobm_pkg::BOOK_DEPTH-1:0] valid_q;

	logic [SB:0]   addr_q;    // read address, one past end when done
	logic [SB:0]   chk_q;     // slot index of data now on rdata
	logic          chk_v_q;
	logic          found_q;
	logic [SB-1:0] best_q;
	logic [PB-1:0] bprice_q;
	logic [IB-1:0] bage_q;
	logic [2:0]    ret_q;

	logic          o_valid_q;
	logic          o_kind_q, o_last_q;
	logic [IB-1:0] o_own_q, o_rest_q;
	logic [QB-1:0] o_fill_q, o_rem_q;
	logic [1:0]    o_st_q;
	logic [CB-1:0] o_cnt_q;

	logic            we;
	logic [SB-1:0]   waddr;
	lobm_pkg::slot_t wdata;
	logic [SB-1:0]   raddr;
	lobm_pkg::slot_t rdata;

	lobm_slot_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign raddr = (state_q == S_RDBST) ? best_q : addr_q[SB-1:0];

	logic [SB-1:0] ci;
	logic          cand;
	logic          better;
	logic [IB-1:0] age;
	assign ci  = chk_q[SB-1:0];
	assign age = idc_q - rdata.ident;

	always_comb begin
		cand   = 1'b0;
		better = 1'b0;
		if (cmd_q == lobm_pkg::CMD_PLACE) begin
			cand = valid_q[ci] && (rdata.side != side_q) &&
				(side_q ? (rdata.price >= price_q) : (rdata.price <= price_q));
			if (!found_q) begin
				better = 1'b1;
			end else if (rdata.price != bprice_q) begin
				better = side_q ? (rdata.price > bprice_q) : (rdata.price < bprice_q);
			end else begin
				better = age > bage_q;
			end
		end else begin
			cand   = valid_q[ci] && (rdata.ident == tid_q);
			better = !found_q;
		end
	end

	logic [QB-1:0] fq;
	logic [QB-1:0] left;
	assign fq   = (rem_q < rdata.qty) ? rem_q : rdata.qty;
	assign left = rdata.qty - fq;

	always_comb begin
		we    = 1'b0;
		waddr = best_q;
		wdata = rdata;
		if (state_q == S_FILL) begin
			wdata.qty = left;
			we = 1'b1;
		end else if (state_q == S_DEC) begin
			wdata.qty = rdata.qty - amt_q;
			we = (cmd_q == lobm_pkg::CMD_REDUCE) && found_q && (amt_q != '0) &&
				(amt_q < rdata.qty);
		end else if (state_q == S_FREE && chk_v_q && !valid_q[ci] && !found_q) begin
			waddr       = ci;
			wdata.side  = side_q;
			wdata.price = price_q;
			wdata.qty   = rem_q;
			wdata.ident = id_q;
			we = 1'b1;
		end
	end

	assign in_ready = (state_q == S_IDLE) && !o_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			idc_q     <= '0;
			book_q    <= '0;
			o_valid_q <= 1'b0;
			chk_v_q   <= 1'b0;
		end else begin
			if (o_valid_q && out_ready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd_q   <= command;
					tid_q   <= target_id;
					price_q <= limit_price[PB-1:0];
					amt_q   <= amount[QB-1:0];
					side_q  <= buy_sell;
					rem_q   <= amount[QB-1:0];
					nfill_q <= '0;
					addr_q  <= '0;
					chk_v_q <= 1'b0;
					found_q <= 1'b0;
					o_kind_q <= lobm_pkg::KIND_SUMMARY;
					o_last_q <= 1'b1;
					o_rest_q <= '0;
					o_fill_q <= '0;
					o_rem_q  <= '0;
					o_st_q   <= lobm_pkg::ST_OK;
					o_cnt_q  <= book_q;
					if (command == lobm_pkg::CMD_PLACE) begin
						if (amount[QB-1:0] == '0) begin
							o_own_q   <= '0;
							o_st_q    <= lobm_pkg::ST_ZERO;
							o_valid_q <= 1'b1;
						end else begin
							idc_q   <= idc_q + 1'b1;
							id_q    <= idc_q + 1'b1;
							state_q <= S_SCAN;
						end
					end else if (command == lobm_pkg::CMD_CANCEL ||
						command == lobm_pkg::CMD_REDUCE) begin
						state_q <= S_SCAN;
					end else begin
						o_own_q   <= '0;
						o_valid_q <= 1'b1;
					end
				end
			end
			S_SCAN, S_FREE: begin
				chk_v_q <= !addr_q[SB];
				chk_q   <= addr_q;
				if (!addr_q[SB]) begin
					addr_q <= addr_q + 1'b1;
				end
				if (chk_v_q && state_q == S_SCAN && cand && better) begin
					found_q  <= 1'b1;
					best_q   <= ci;
					bprice_q <= rdata.price;
					bage_q   <= age;
				end
				if (chk_v_q && state_q == S_FREE && !valid_q[ci] && !found_q) begin
					found_q     <= 1'b1;
					valid_q[ci] <= 1'b1;
					book_q      <= book_q + 1'b1;
				end
				if (!chk_v_q && addr_q[SB]) begin
					if (state_q == S_FREE) begin
						o_kind_q  <= lobm_pkg::KIND_SUMMARY;
						o_last_q  <= 1'b1;
						o_own_q   <= id_q;
						o_rest_q  <= '0;
						o_fill_q  <= '0;
						o_rem_q   <= rem_q;
						o_st_q    <= found_q ? lobm_pkg::ST_OK : lobm_pkg::ST_FULL;
						o_cnt_q   <= book_q;
						o_valid_q <= 1'b1;
						state_q   <= S_WAIT;
						ret_q     <= S_IDLE;
					end else if (cmd_q == lobm_pkg::CMD_PLACE) begin
						state_q <= found_q ? S_RDBST : S_FREE;
						addr_q  <= '0;
						found_q <= 1'b0;
					end else begin
						state_q <= found_q ? S_RDBST : S_WAIT;
						ret_q   <= found_q ? S_DEC : S_IDLE;
						if (!found_q) begin
							o_own_q   <= tid_q;
							o_st_q    <= lobm_pkg::ST_UNKNOWN;
							o_valid_q <= 1'b1;
						end
					end
				end
			end
			S_RDBST: begin
				state_q <= (cmd_q == lobm_pkg::CMD_PLACE) ? S_FILL : S_DEC;
			end
			S_FILL: begin
				rem_q   <= rem_q - fq;
				nfill_q <= nfill_q + 1'b1;
				if (left == '0) begin
					valid_q[best_q] <= 1'b0;
					book_q <= book_q - 1'b1;
				end
				o_kind_q  <= lobm_pkg::KIND_FILL;
				o_last_q  <= 1'b0;
				o_own_q   <= id_q;
				o_rest_q  <= rdata.ident;
				o_fill_q  <= fq;
				o_rem_q   <= rem_q - fq;
				o_st_q    <= lobm_pkg::ST_OK;
				o_cnt_q   <= (left == '0) ? book_q - 1'b1 : book_q;
				o_valid_q <= 1'b1;
				addr_q    <= '0;
				chk_v_q   <= 1'b0;
				found_q   <= 1'b0;
				state_q   <= S_WAIT;
				if (rem_q == fq) begin
					ret_q <= S_IDLE;
				end else if (nfill_q + 1'b1 == CB'(lobm_pkg::MAX_FILLS)) begin
					ret_q <= S_FREE;
				end else begin
					ret_q <= S_SCAN;
				end
			end
			S_DEC: begin
				o_own_q <= tid_q;
				o_st_q  <= lobm_pkg::ST_OK;
				o_rem_q <= '0;
				if (cmd_q == lobm_pkg::CMD_CANCEL || amt_q >= rdata.qty) begin
					valid_q[best_q] <= 1'b0;
					book_q  <= book_q - 1'b1;
					o_cnt_q <= book_q - 1'b1;
				end else if (amt_q == '0) begin
					o_st_q  <= lobm_pkg::ST_ZERO;
					o_rem_q <= rdata.qty;
				end else begin
					o_rem_q <= rdata.qty - amt_q;
				end
				o_valid_q <= 1'b1;
				state_q   <= S_WAIT;
				ret_q     <= S_IDLE;
			end
			S_WAIT: begin
				if (!o_valid_q || out_ready) begin
					if (ret_q == S_IDLE && o_kind_q == lobm_pkg::KIND_FILL) begin
						o_kind_q  <= lobm_pkg::KIND_SUMMARY;
						o_last_q  <= 1'b1;
						o_rest_q  <= '0;
						o_fill_q  <= '0;
						o_valid_q <= 1'b1;
					end else begin
						state_q <= ret_q;
					end
				end
			end
			default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = o_valid_q;
	assign kind          = o_kind_q;
	assign own_id        = o_own_q;
	assign resting_id    = o_rest_q;
	assign fill_amount   = o_fill_q;
	assign remaining     = o_rem_q;
	assign status        = o_st_q;
	assign resting_count = 7'(o_cnt_q);
	assign last          = o_last_q;
endmodule

/* rtl/lobm_checker.sv */
// ----------------------------------------------------------------------------
// lobm_checker: port-level checks of the order book matcher
// Result framing and handshake behaviour seen at the ports.
// ----------------------------------------------------------------------------
module lobm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic        last,
	input logic [1:0]  status,
	input logic [23:0] fill_amount,
	input logic [6:0]  resting_count
);
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last == kind)) else $error("last and kind disagree");

	a_fill_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> status == 2'd0 && fill_amount != '0)
		else $error("bad fill item");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> resting_count <= 7'd64) else $error("count beyond depth");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind))
		else $error("result dropped under stall");
endmodule

bind limit_order_book_matcher lobm_checker u_lobm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.kind          (kind),
	.last          (last),
	.status        (status),
	.fill_amount   (fill_amount),
	.resting_count (resting_count)
);

/* bench/limit_order_book_matcher_tb.sv */
// ----------------------------------------------------------------------------
// limit_order_book_matcher_tb: self-checking bench for the order book matcher
// Place, cancel, reduce and undefined-command items go in from a queue; every fill and summary
// that comes out is compared field by field with a book model held here.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_tb;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] tid;
		logic [15:0] price;
		logic [23:0] amt;
		logic        side;
	} order_cmd_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] own;
		logic [31:0] rest;
		logic [23:0] fill;
		logic [23:0] rem;
		logic [1:0]  st;
		logic [6:0]  cnt;
		logic        last;
	} book_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = '0;
	logic [31:0] target_id = '0;
	logic [15:0] limit_price = '0;
	logic [23:0] amount = '0;
	logic        buy_sell = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [31:0] own_id;
	logic [31:0] resting_id;
	logic [23:0] fill_amount;
	logic [23:0] remaining;
	logic [1:0]  status;
	logic [6:0]  resting_count;
	logic        last;

	limit_order_book_matcher dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// book model
	logic        bk_valid [lobm_pkg::BOOK_DEPTH];
	logic        bk_side  [lobm_pkg::BOOK_DEPTH];
	logic [15:0] bk_price [lobm_pkg::BOOK_DEPTH];
	logic [23:0] bk_qty   [lobm_pkg::BOOK_DEPTH];
	logic [31:0] bk_ident [lobm_pkg::BOOK_DEPTH];
	logic [31:0] next_id;
	logic [6:0]  bk_count;

	order_cmd_t   pending_cmds[$];
	book_result_t expected_results[$];
	int errors = 0;
	int fills_seen = 0;
	int summaries_seen = 0;
	int send_idle = 22;
	int recv_idle = 60;
	bit sending = 1'b0;

	function automatic void queue_cmd(order_cmd_t c);
		pending_cmds.insert(pending_cmds.size(), c);
	endfunction

	function automatic book_result_t mk(logic k, logic [31:0] own, logic [31:0] rest,
			logic [23:0] fill, logic [23:0] rem, logic [1:0] st);
		book_result_t r;
		r = '{k, own, rest, fill, rem, st, bk_count, k};
		return r;
	endfunction

	function automatic void expect_result(book_result_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic int find_order(logic [31:0] id);
		for (int i = 0; i < lobm_pkg::BOOK_DEPTH; i++)
			if (bk_valid[i] && bk_ident[i] == id) return i;
		return -1;
	endfunction

	function automatic int best_opposite(logic side, logic [15:0] price);
		int best;
		best = -1;
		for (int i = 0; i < lobm_pkg::BOOK_DEPTH; i++) begin
			if (!bk_valid[i] || bk_side[i] == side) continue;
			if (side == 1'b0 ? bk_price[i] > price : bk_price[i] < price) continue;
			if (best < 0) begin
				best = i;
			end else if (bk_price[i] != bk_price[best]) begin
				if (side == 1'b0 ? bk_price[i] < bk_price[best] : bk_price[i] > bk_price[best])
					best = i;
			end else if (32'(next_id - bk_ident[i]) > 32'(next_id - bk_ident[best])) begin
				best = i;
			end
		end
		return best;
	endfunction

	task automatic predict_book(order_cmd_t c);
		int s, m, n;
		logic [23:0] rem, f;
		if (c.cmd == lobm_pkg::CMD_PLACE) begin
			if (c.amt == '0) begin
				expect_result(mk(lobm_pkg::KIND_SUMMARY, '0, '0, '0, '0, lobm_pkg::ST_ZERO));
				return;
			end
			next_id++;
			rem = c.amt;
			n = 0;
			while (rem > 0 && n < lobm_pkg::MAX_FILLS) begin
				m = best_opposite(c.side, c.price);
				if (m < 0) break;
				f = rem < bk_qty[m] ? rem : bk_qty[m];
				rem -= f;
				bk_qty[m] -= f;
				if (bk_qty[m] == '0) begin
					bk_valid[m] = 1'b0;
					bk_count--;
				end
				expect_result(mk(lobm_pkg::KIND_FILL, next_id, bk_ident[m], f, rem,
					lobm_pkg::ST_OK));
				n++;
			end
			if (rem > 0) begin
				s = -1;
				for (int i = lobm_pkg::BOOK_DEPTH - 1; i >= 0; i--)
					if (!bk_valid[i]) s = i;
				if (s < 0) begin
					expect_result(mk(lobm_pkg::KIND_SUMMARY, next_id, '0, '0, rem,
						lobm_pkg::ST_FULL));
					return;
				end
				bk_valid[s] = 1'b1;
				bk_side[s] = c.side;
				bk_price[s] = c.price;
				bk_qty[s] = rem;
				bk_ident[s] = next_id;
				bk_count++;
			end
			expect_result(mk(lobm_pkg::KIND_SUMMARY, next_id, '0, '0, rem, lobm_pkg::ST_OK));
		end else if (c.cmd == lobm_pkg::CMD_CANCEL || c.cmd == lobm_pkg::CMD_REDUCE) begin
			s = find_order(c.tid);
			if (s < 0) begin
				expect_result(mk(lobm_pkg::KIND_SUMMARY, c.tid, '0, '0, '0,
					lobm_pkg::ST_UNKNOWN));
			end else if (c.cmd == lobm_pkg::CMD_REDUCE && c.amt == '0) begin
				expect_result(mk(lobm_pkg::KIND_SUMMARY, c.tid, '0, '0, bk_qty[s],
					lobm_pkg::ST_ZERO));
			end else if (c.cmd == lobm_pkg::CMD_CANCEL || c.amt >= bk_qty[s]) begin
				bk_valid[s] = 1'b0;
				bk_count--;
				expect_result(mk(lobm_pkg::KIND_SUMMARY, c.tid, '0, '0, '0, lobm_pkg::ST_OK));
			end else begin
				bk_qty[s] -= c.amt;
				expect_result(mk(lobm_pkg::KIND_SUMMARY, c.tid, '0, '0, bk_qty[s],
					lobm_pkg::ST_OK));
			end
		end else begin
			expect_result(mk(lobm_pkg::KIND_SUMMARY, '0, '0, '0, '0, lobm_pkg::ST_OK));
		end
	endtask

	// driver: the item on the pins stays at the queue head until accepted
	always @(posedge clk) begin
		order_cmd_t h;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_book(pending_cmds.pop_front());
			end
			if (!in_valid || in_ready) begin
				if (sending && pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
					h = pending_cmds[0];
					in_valid <= 1'b1;
					command <= h.cmd;
					target_id <= h.tid;
					limit_price <= h.price;
					amount <= h.amt;
					buy_sell <= h.side;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		book_result_t got, want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{kind, own_id, resting_id, fill_amount, remaining, status,
					resting_count, last};
				if (kind == lobm_pkg::KIND_FILL) fills_seen++; else summaries_seen++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %p", $time, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						$display("%0t: expected %p", $time, want);
						$display("%0t: actual   %p", $time, got);
					end
				end
			end
			out_ready <= $urandom_range(99) >= recv_idle;
		end
	end

	function automatic order_cmd_t place(logic side, logic [15:0] p, logic [23:0] q);
		order_cmd_t c;
		c = '{lobm_pkg::CMD_PLACE, $urandom, p, q, side};
		return c;
	endfunction

	function automatic order_cmd_t by_id(logic [1:0] op, logic [31:0] id, logic [23:0] q);
		order_cmd_t c;
		c = '{op, id, 16'($urandom), q, 1'($urandom)};
		return c;
	endfunction

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int ids;
		for (int i = 0; i < lobm_pkg::BOOK_DEPTH; i++) bk_valid[i] = 1'b0;
		next_id = '0;
		bk_count = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		queue_cmd(place(1'b0, 16'd100, 24'd0));
		queue_cmd(place(1'b0, 16'd100, 24'd10));
		queue_cmd(place(1'b0, 16'd100, 24'd5));
		queue_cmd(place(1'b0, 16'd0, 24'hFFFFFF));
		queue_cmd(place(1'b1, 16'hFFFF, 24'd7));
		queue_cmd(place(1'b1, 16'd90, 24'd12));
		queue_cmd(by_id(lobm_pkg::CMD_REDUCE, 32'd4, 24'd0));
		queue_cmd(by_id(lobm_pkg::CMD_REDUCE, 32'd5, 24'd1));
		queue_cmd(by_id(lobm_pkg::CMD_REDUCE, 32'd5, 24'hFFFFFF));
		queue_cmd(by_id(lobm_pkg::CMD_CANCEL, 32'd4, 24'd0));
		queue_cmd(by_id(lobm_pkg::CMD_CANCEL, 32'hFFFFFFFF, 24'd3));
		queue_cmd(by_id(lobm_pkg::CMD_REDUCE, 32'd0, 24'd3));
		queue_cmd(by_id(2'd3, 32'd2, 24'd3));
		queue_cmd(place(1'b1, 16'd0, 24'hFFFFFF));
		sending = 1'b1;
		drain();

		// fill the book, overflow, then one place with many fills
		for (int i = 0; i < lobm_pkg::BOOK_DEPTH + 1; i++)
			queue_cmd(place(1'b1, 16'(200 + i % 3), 24'd1));
		queue_cmd(place(1'b0, 16'hFFFF, 24'hFFFFFF));
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = ph == 0 ? 22 : (ph == 1 ? 60 : 0);
			recv_idle = ph == 0 ? 60 : (ph == 1 ? 22 : 0);
			for (int k = 0; k < 100; k++) begin
				ids = $urandom_range(99);
				if (ids < 55)
					queue_cmd(place(1'($urandom),
						16'(1000 + $urandom_range(15)),
						$urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(20))));
				else if (ids < 75)
					queue_cmd(by_id(lobm_pkg::CMD_CANCEL,
						next_id + pending_cmds.size() - $urandom_range(30), 24'($urandom)));
				else if (ids < 95)
					queue_cmd(by_id(lobm_pkg::CMD_REDUCE,
						next_id + pending_cmds.size() - $urandom_range(30),
						$urandom_range(9) == 0 ? 24'($urandom) : 24'($urandom_range(8))));
				else
					queue_cmd(by_id(2'($urandom), $urandom, 24'($urandom)));
			end
			drain();
		end
		repeat (200) @(posedge clk);
		$display("Covered %0d fills and %0d summaries, book fill and overflow, idle mixes.",
			fills_seen, summaries_seen);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#100000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
